### rtl/core/rfr_pkg.sv
// Package for the request FIFO with remove-by-id core.
// Holds the operation and status codes and the per-cell control struct.
// No dependencies.
package rfr_pkg;

    localparam int ID_W    = 16;
    localparam int STAMP_W = 48;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_ENQ    = 2'd0;
    localparam mode_t MODE_DEQ    = 2'd1;
    localparam mode_t MODE_REMOVE = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    // Already qualified by accept, fullness and emptiness.
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
    } cell_ctrl_t;

endpackage

### rtl/core/rfr_cell.sv
// One queue slot: holds an id and a timestamp, loads on enqueue,
// takes its upper neighbor's entry to close a gap. Depends on rfr_pkg.
module rfr_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  rfr_pkg::cell_ctrl_t           ctrl,
    input  logic [CNT_W-1:0]              count,
    input  logic [rfr_pkg::ID_W-1:0]      key,
    input  logic [rfr_pkg::ID_W-1:0]      new_id,
    input  logic [rfr_pkg::STAMP_W-1:0]   new_stamp,
    input  logic [rfr_pkg::ID_W-1:0]      up_id,
    input  logic [rfr_pkg::STAMP_W-1:0]   up_stamp,
    input  logic                          found_in,
    output logic                          found_out,
    output logic [rfr_pkg::ID_W-1:0]      cur_id,
    output logic [rfr_pkg::STAMP_W-1:0]   cur_stamp
);

    logic [rfr_pkg::ID_W-1:0]    id_reg;
    logic [rfr_pkg::STAMP_W-1:0] stamp_reg;
    logic                        occupied;
    logic                        load;
    logic                        shift;

    assign occupied  = CNT_W'(IDX) < count;
    assign found_out = found_in | (occupied && (id_reg == key));
    assign load      = ctrl.enq && (CNT_W'(IDX) == count);
    assign shift     = ctrl.deq || (ctrl.rem && found_out);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg    <= new_id;
            stamp_reg <= new_stamp;
        end
        else if (shift)
        begin
            id_reg    <= up_id;
            stamp_reg <= up_stamp;
        end
    end

    assign cur_id    = id_reg;
    assign cur_stamp = stamp_reg;

endmodule

### rtl/core/rfr_array.sv
// Row of queue cells, head at cell 0, with the match chain running upward.
// Depends on rfr_pkg and rfr_cell.
module rfr_array #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = 5
) (
    input  logic                          clk,
    input  rfr_pkg::cell_ctrl_t           ctrl,
    input  logic [CNT_W-1:0]              count,
    input  logic [rfr_pkg::ID_W-1:0]      key,
    input  logic [rfr_pkg::ID_W-1:0]      new_id,
    input  logic [rfr_pkg::STAMP_W-1:0]   new_stamp,
    output logic [rfr_pkg::ID_W-1:0]      head_id,
    output logic [rfr_pkg::STAMP_W-1:0]   head_stamp,
    output logic                          found
);

    logic [rfr_pkg::ID_W-1:0]    ids    [QUEUE_DEPTH+1];
    logic [rfr_pkg::STAMP_W-1:0] stamps [QUEUE_DEPTH+1];
    logic                        chain  [QUEUE_DEPTH+1];

    assign chain[0]            = 1'b0;
    assign ids[QUEUE_DEPTH]    = '0;
    assign stamps[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rfr_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count),
            .key       (key),
            .new_id    (new_id),
            .new_stamp (new_stamp),
            .up_id     (ids[i+1]),
            .up_stamp  (stamps[i+1]),
            .found_in  (chain[i]),
            .found_out (chain[i+1]),
            .cur_id    (ids[i]),
            .cur_stamp (stamps[i])
        );
    end

    assign head_id    = ids[0];
    assign head_stamp = stamps[0];
    assign found      = chain[QUEUE_DEPTH];

endmodule

### rtl/core/request_fifo_with_remove_by_id_core.sv
// Top level of the request FIFO with remove-by-id: count, op decode, result register.
// Depends on rfr_pkg, rfr_array, rfr_cell.
//
//  port group  dir  tdata (low bit up)                      tuser
//  s_*         in   conn_id[15:0], arrival_time[63:16]      mode[1:0]
//  m_*         out  out_conn_id, out_arrival, occupancy     status[1:0]
//
// One request per cycle while s_tready is high; its result is registered and shown the next cycle.
// Remove finds the oldest match through a ripple chain over all cells.
// rst_n clears the count and the result valid; slot contents are not reset.
// s_tready is high when the result register is empty or being taken.
module request_fifo_with_remove_by_id_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // conn_id[15:0], arrival_time[63:16]
    input  logic [1:0]           s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((64 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
                                 // out_conn_id[15:0], out_arrival[63:16], occupancy above
    output logic [1:0]           m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((64 + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    rfr_pkg::status_t            status_reg;
    rfr_pkg::status_t            status_next;
    logic [rfr_pkg::ID_W-1:0]    oid_reg;
    logic [rfr_pkg::ID_W-1:0]    oid_next;
    logic [rfr_pkg::STAMP_W-1:0] ostamp_reg;
    logic [rfr_pkg::STAMP_W-1:0] ostamp_next;
    logic [CNT_W-1:0]            occ_reg;

    rfr_pkg::mode_t              mode;
    logic [rfr_pkg::ID_W-1:0]    in_id;
    logic [rfr_pkg::STAMP_W-1:0] in_stamp;
    logic                        fire;
    logic                        full;
    logic                        empty;
    rfr_pkg::cell_ctrl_t         ctrl;
    logic [rfr_pkg::ID_W-1:0]    head_id;
    logic [rfr_pkg::STAMP_W-1:0] head_stamp;
    logic                        found;

    assign mode     = s_tuser;
    assign in_id    = s_tdata[15:0];
    assign in_stamp = s_tdata[63:16];
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;

    always_comb
    begin
        ctrl        = '0;
        status_next = rfr_pkg::ST_OK;
        oid_next    = '0;
        ostamp_next = '0;
        count_next  = count_reg;
        unique case (mode)
            rfr_pkg::MODE_ENQ:
            begin
                if (full)
                    status_next = rfr_pkg::ST_FULL;
                else
                begin
                    ctrl.enq   = fire;
                    count_next = count_reg + 1'b1;
                end
            end
            rfr_pkg::MODE_DEQ:
            begin
                if (empty)
                    status_next = rfr_pkg::ST_EMPTY;
                else
                begin
                    ctrl.deq    = fire;
                    oid_next    = head_id;
                    ostamp_next = head_stamp;
                    count_next  = count_reg - 1'b1;
                end
            end
            rfr_pkg::MODE_REMOVE:
            begin
                if (empty)
                    status_next = rfr_pkg::ST_EMPTY;
                else if (found)
                begin
                    ctrl.rem   = fire;
                    count_next = count_reg - 1'b1;
                end
                else
                    status_next = rfr_pkg::ST_NOTFOUND;
            end
            default:
            begin
                status_next = rfr_pkg::ST_OK;
            end
        endcase
    end

    rfr_array #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_array (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .key        (in_id),
        .new_id     (in_id),
        .new_stamp  (in_stamp),
        .head_id    (head_id),
        .head_stamp (head_stamp),
        .found      (found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            oid_reg    <= oid_next;
            ostamp_reg <= ostamp_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({occ_reg, ostamp_reg, oid_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode == rfr_pkg::MODE_ENQ && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode == rfr_pkg::MODE_ENQ && full
        |=> m_tuser == rfr_pkg::ST_FULL && $stable(count_reg))
        else $error("enqueue on full queue not dropped");

    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> occ_reg == count_reg && m_tvalid)
        else $error("reported occupancy differs from count");

    a_notfound_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode == rfr_pkg::MODE_REMOVE && !empty && !found
        |=> m_tuser == rfr_pkg::ST_NOTFOUND && $stable(count_reg))
        else $error("remove without match changed the queue");

endmodule

### tb/request_fifo_with_remove_by_id_core_tb.sv
// Self-checking testbench for request_fifo_with_remove_by_id_core: a stream driver and monitor
// around a cycle-free queue predictor, directed corner requests, then biased random traffic.
// Depends on rfr_pkg and the core RTL.
module request_fifo_with_remove_by_id_core_tb;

    localparam int ID_W        = rfr_pkg::ID_W;
    localparam int STAMP_W     = rfr_pkg::STAMP_W;
    localparam int DEPTH       = 16;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int M_W         = ((64 + OCC_W + 7) / 8) * 8;
    localparam int RANDOM_REQS = 800;
    localparam int CYCLE_LIMIT = 200000;
    localparam rfr_pkg::mode_t MODE_UNUSED = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct {
        rfr_pkg::mode_t     mode;
        logic [ID_W-1:0]    conn_id;
        logic [STAMP_W-1:0] stamp;
        bit                 drain_first;
    } fifo_req_t;

    typedef struct {
        rfr_pkg::status_t   status;
        logic [ID_W-1:0]    conn_id;
        logic [STAMP_W-1:0] stamp;
        logic [OCC_W-1:0]   occupancy;
    } fifo_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata = '0;   // conn_id[15:0], arrival_time[63:16]
    logic [1:0]         s_tuser = '0;   // mode[1:0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [M_W-1:0]     m_tdata;        // out_conn_id[15:0], out_arrival[63:16], occupancy
    logic [1:0]         m_tuser;        // status[1:0]

    fifo_req_t          pending_reqs[$];
    fifo_result_t       expected_results[$];
    logic [ID_W-1:0]    shadow_ids[DEPTH];
    logic [STAMP_W-1:0] shadow_stamps[DEPTH];
    int                 shadow_count = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    request_fifo_with_remove_by_id_core #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit idle_roll();
        if (cycle_count >= 1500 && cycle_count < 2500)
            return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    // Apply one request to the shadow queue and return the result it yields.
    function automatic fifo_result_t apply_request(fifo_req_t req);
        fifo_result_t res;
        int           hit;
        res.status  = rfr_pkg::ST_OK;
        res.conn_id = '0;
        res.stamp   = '0;
        hit         = -1;
        case (req.mode)
            rfr_pkg::MODE_ENQ:
            begin
                if (shadow_count >= DEPTH)
                    res.status = rfr_pkg::ST_FULL;
                else
                begin
                    shadow_ids[shadow_count]    = req.conn_id;
                    shadow_stamps[shadow_count] = req.stamp;
                    shadow_count++;
                end
            end
            rfr_pkg::MODE_DEQ:
            begin
                if (shadow_count == 0)
                    res.status = rfr_pkg::ST_EMPTY;
                else
                begin
                    res.conn_id = shadow_ids[0];
                    res.stamp   = shadow_stamps[0];
                    hit         = 0;
                end
            end
            rfr_pkg::MODE_REMOVE:
            begin
                if (shadow_count == 0)
                    res.status = rfr_pkg::ST_EMPTY;
                else
                begin
                    for (int i = shadow_count - 1; i >= 0; i--)
                        if (shadow_ids[i] == req.conn_id)
                            hit = i;
                    if (hit < 0)
                        res.status = rfr_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        if (hit >= 0)
        begin
            for (int j = hit; j < shadow_count - 1; j++)
            begin
                shadow_ids[j]    = shadow_ids[j + 1];
                shadow_stamps[j] = shadow_stamps[j + 1];
            end
            shadow_count--;
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val)
            note_error($sformatf("%s mismatch: expected %0h, got %0h", name, exp_val, act_val));
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(pending_reqs.pop_front()));
            if (s_tvalid && !s_tready)
                ;
            else if (pending_reqs.size() != 0 && !idle_roll()
                     && !(pending_reqs[0].drain_first && expected_results.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_reqs[0].stamp, pending_reqs[0].conn_id};
                s_tuser  <= pending_reqs[0].mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        fifo_result_t exp_res;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    note_error("result with no pending request");
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("status", exp_res.status, m_tuser);
                    check_field("out_conn_id", exp_res.conn_id, m_tdata[15:0]);
                    check_field("out_arrival", exp_res.stamp, m_tdata[63:16]);
                    check_field("occupancy", exp_res.occupancy, m_tdata[64 +: OCC_W]);
                end
            end
            m_tready <= !idle_roll();
        end
    end

    task automatic add_req(rfr_pkg::mode_t mode, logic [ID_W-1:0] id,
                           logic [STAMP_W-1:0] stamp, bit drain = 1'b0);
        fifo_req_t req;
        req.mode        = mode;
        req.conn_id     = id;
        req.stamp       = stamp;
        req.drain_first = drain;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return ID_W'($urandom_range(7));
        if (r < 70)
            return {ID_W{1'b1}};
        return ID_W'($urandom);
    endfunction

    function automatic logic [STAMP_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return STAMP_MAX;
        return STAMP_W'({$urandom, $urandom});
    endfunction

    initial
    begin
        int             r;
        int             enq_pct;
        rfr_pkg::mode_t mode;

        // empty-queue corners and the unused mode
        add_req(rfr_pkg::MODE_DEQ, 16'h1234, STAMP_MAX);
        add_req(rfr_pkg::MODE_REMOVE, 16'h0000, '0);
        add_req(MODE_UNUSED, 16'hFFFF, STAMP_MAX);
        // fill to capacity with extreme and duplicate ids, try one enqueue too many, then remove and dequeue
        add_req(rfr_pkg::MODE_ENQ, 16'h0000, '0);
        add_req(rfr_pkg::MODE_ENQ, 16'hFFFF, STAMP_MAX);
        add_req(rfr_pkg::MODE_ENQ, 16'h0005, 48'h5555_5555_5555);
        for (int i = 0; i < 12; i++)
            add_req(rfr_pkg::MODE_ENQ, (i % 3 == 0) ? 16'h0005 : ID_W'(16'h0100 + i),
                    pick_stamp());
        add_req(rfr_pkg::MODE_ENQ, 16'hAAAA, 48'hAAAA_AAAA_AAAA);
        add_req(rfr_pkg::MODE_ENQ, 16'h7777, 48'h1);
        add_req(MODE_UNUSED, 16'h0000, '0);
        add_req(rfr_pkg::MODE_REMOVE, 16'h4321, '0);
        add_req(rfr_pkg::MODE_REMOVE, 16'h0005, '0);
        add_req(rfr_pkg::MODE_REMOVE, 16'h010B, '0);
        add_req(rfr_pkg::MODE_DEQ, 16'h0000, '0);
        add_req(rfr_pkg::MODE_DEQ, 16'hFFFF, '0);

        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            enq_pct = ((k / 100) % 2 == 0) ? 65 : 30;
            r = $urandom_range(99);
            if (r < 3)
                mode = MODE_UNUSED;
            else if (r < 3 + enq_pct)
                mode = rfr_pkg::MODE_ENQ;
            else if ($urandom_range(1))
                mode = rfr_pkg::MODE_DEQ;
            else
                mode = rfr_pkg::MODE_REMOVE;
            add_req(mode, pick_id(), pick_stamp(), k == 0 || k == 400);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            note_error("results missing at end of run");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/rfr_pkg.sv
rtl/core/rfr_cell.sv
rtl/core/rfr_array.sv
rtl/core/request_fifo_with_remove_by_id_core.sv
tb/request_fifo_with_remove_by_id_core_tb.sv
